// ----- hdl/bat_pkg.sv -----
package bat_pkg;

    localparam int MAX_BREAKPOINTS = 16;
    localparam int IDX_W = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
    localparam int CNT_W = $clog2(MAX_BREAKPOINTS + 1);

    localparam int OP_W      = 3;
    localparam int ADDR_W    = 16;
    localparam int PMS_W     = 17;
    localparam int STATUS_W  = 3;
    localparam int OUT_CNT_W = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd0;
    localparam logic [OP_W-1:0] OP_SET       = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd2;
    localparam logic [OP_W-1:0] OP_TOGGLE    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_DONE        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_ADDRESS = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL        = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_PRESENT     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_MEMORY_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_ADDRESS        = 1'd1;

    localparam logic [PMS_W-1:0] PMS_RESET = 17'h10000;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_DECIDE,
        SEQ_MOVE,
        SEQ_RESULT
    } seq_state_t;

    typedef struct packed {
        logic [PMS_W-1:0]  program_memory_size;
        logic [ADDR_W-1:0] stop_addr;
    } cfg_t;

    typedef struct packed {
        logic                 entry_hit;
        logic                 stop_hit;
        logic [STATUS_W-1:0]  status;
        logic [OUT_CNT_W-1:0] entry_count;
    } result_t;

endpackage

// ----- hdl/breakpoint_address_table_top.sv -----
// Breakpoint address table with a single stop point.
// Input channel (s_*): one command transaction per item, opcode and address
// in s_tdata. Result channel (m_*): one result transaction per command with
// breakpoint hit, stop hit, status and the entry count after the command.
// Configuration: cfg_we/cfg_index/cfg_wdata write program_memory_size
// (index 0) and the stop point address (index 1); write only while no command is open.
// Operation: a command scans the stored entries one per cycle through a single
// comparator on the registered read port of the entry memory, visiting all
// stored entries or those up to and including the match; a successful clear
// then moves the last entry into the freed slot. s_tready stays low from
// acceptance until the result is handed to the output register, so the engine
// holds at most one command and takes the next one only after that handover.
// Reset (aresetn low, synchronous) empties the table, restores
// program_memory_size to 65536 and the stop point to 0, and drops any result.
// When the receiver stalls, the output register holds the result and the
// engine takes the next command; a second result waits in the engine.
module breakpoint_address_table_top import bat_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [2:0] opcode, [18:3] address, rest zero
    // Result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [0] entry_hit, [1] stop_hit,
                                            // [4:2] status, [9:5] entry_count, rest zero
    // Configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PMS_W-1:0]     cfg_wdata
);

    cfg_t    cfg_reg;
    logic    m_tvalid_reg, m_tvalid_next;
    result_t m_res_reg, m_res_next;
    logic    res_valid;
    logic    res_ready;
    result_t res;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.program_memory_size <= PMS_RESET;
            cfg_reg.stop_addr           <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PROGRAM_MEMORY_SIZE: cfg_reg.program_memory_size <= cfg_wdata;
                CFG_STOP_ADDRESS:        cfg_reg.stop_addr <= cfg_wdata[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bat_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_opcode  (s_tdata[OP_W-1:0]),
        .in_address (s_tdata[OP_W+ADDR_W-1:OP_W]),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: advance when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_res_next    = res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_res_reg.entry_count, m_res_reg.status,
                       m_res_reg.stop_hit, m_res_reg.entry_hit};

endmodule

// ----- hdl/bat_engine.sv -----
module bat_engine import bat_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   in_opcode,
    input  logic [ADDR_W-1:0] in_address,
    input  cfg_t              cfg,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    // Breakpoint storage, one write and one registered read port
    logic [ADDR_W-1:0] mem [MAX_BREAKPOINTS];
    logic [ADDR_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ADDR_W-1:0] wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    seq_state_t          state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    found_idx_reg, found_idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [CNT_W-1:0]    last_cnt;
    logic [OP_W-1:0]     eff_op;
    logic                bad_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        op_reg        <= op_next;
        addr_reg      <= addr_next;
        scan_idx_reg  <= scan_idx_next;
        cmp_valid_reg <= cmp_valid_next;
        cmp_idx_reg   <= cmp_idx_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        status_reg    <= status_next;
    end

    assign last_cnt = count_reg - CNT_W'(1);
    assign bad_addr = PMS_W'(addr_reg) >= cfg.program_memory_size;

    always_comb begin
        if (op_reg == OP_TOGGLE) begin
            eff_op = found_reg ? OP_CLEAR : OP_SET;
        end else begin
            eff_op = op_reg;
        end
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        rd_addr        = scan_idx_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];
        wr_data        = addr_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            SEQ_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next        = in_opcode;
                    addr_next      = in_address;
                    scan_idx_next  = '0;
                    cmp_valid_next = 1'b0;
                    found_next     = 1'b0;
                    state_next     = SEQ_SCAN;
                end
            end
            SEQ_SCAN: begin
                // compare the entry read last cycle, issue the next read
                if (cmp_valid_reg && (rd_data_reg == addr_reg)) begin
                    found_next     = 1'b1;
                    found_idx_next = cmp_idx_reg;
                    state_next     = SEQ_DECIDE;
                end else if (scan_idx_reg < count_reg) begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next  = scan_idx_reg + CNT_W'(1);
                end else begin
                    state_next = SEQ_DECIDE;
                end
            end
            SEQ_DECIDE: begin
                status_next = STAT_DONE;
                state_next  = SEQ_RESULT;
                case (eff_op)
                    OP_SET: begin
                        if (bad_addr) begin
                            status_next = STAT_BAD_ADDRESS;
                        end else if (found_reg) begin
                            status_next = STAT_PRESENT;
                        end else if (count_reg >= CNT_W'(MAX_BREAKPOINTS)) begin
                            status_next = STAT_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_CLEAR: begin
                        if (bad_addr) begin
                            status_next = STAT_BAD_ADDRESS;
                        end else if (!found_reg) begin
                            status_next = STAT_NOT_FOUND;
                        end else begin
                            // fetch the last entry to fill the freed slot
                            rd_addr    = last_cnt[IDX_W-1:0];
                            state_next = SEQ_MOVE;
                        end
                    end
                    OP_CLEAR_ALL: begin
                        count_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
            SEQ_MOVE: begin
                wr_en      = 1'b1;
                wr_addr    = found_idx_reg;
                wr_data    = rd_data_reg;
                count_next = last_cnt;
                state_next = SEQ_RESULT;
            end
            SEQ_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign res.entry_hit   = found_reg;
    assign res.stop_hit    = (cfg.stop_addr != '0) && (cfg.stop_addr == addr_reg);
    assign res.status      = status_reg;
    assign res.entry_count = OUT_CNT_W'(count_reg);

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_BREAKPOINTS))
        else $error("breakpoint count above table size");

    a_move_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_MOVE) |-> (count_reg != '0) && found_reg)
        else $error("entry move with empty table or no match");

    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == SEQ_SCAN))
        else $error("accepted transaction did not start a scan");

    a_set_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_DECIDE && wr_en) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("set did not grow the table by one");

    a_found_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_DECIDE && found_reg) |-> (CNT_W'(found_idx_reg) < count_reg))
        else $error("match index outside stored entries");
`endif

endmodule

// ----- test/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bat_pkg::*;

    localparam int          CLK_HALF        = 10;
    localparam int          RESET_CYCLES    = 5;
    localparam int          NUM_PHASES      = 6;
    localparam int          ITEMS_PER_PHASE = 100;
    localparam int          POOL_SIZE       = 24;
    localparam int          HOLD_OFF_CYCLES = 250;
    localparam int          TAIL_CYCLES     = 40;
    localparam int unsigned RUN_LIMIT_NS    = 6_000_000;

    // Opcodes with no command of their own; the block treats them as lookup.
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    typedef enum bit {
        ROW_CMD,
        ROW_REG_WRITE
    } row_kind_t;

    // One line of the directed sequence: either a command (value carries the address,
    // issued reps times with the address stepping up by one) or a register write.
    typedef struct {
        row_kind_t            kind;
        logic [OP_W-1:0]      op;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [PMS_W-1:0]     value;
        int                   reps;
        bit                   typed;
        result_t              res;
    } cmd_row_t;

    localparam int NUM_ROWS = 18;

    cmd_row_t directed_rows [NUM_ROWS] = '{
        // Fill the table: two extreme addresses, then fourteen more.
        '{ROW_CMD, OP_SET, CFG_PROGRAM_MEMORY_SIZE, 17'h00000, 1, 1'b1,
          '{1'b0, 1'b0, STAT_DONE, 5'd1}},
        '{ROW_CMD, OP_SET, CFG_PROGRAM_MEMORY_SIZE, 17'h0FFFF, 1, 1'b1,
          '{1'b0, 1'b0, STAT_DONE, 5'd2}},
        '{ROW_CMD, OP_SET, CFG_PROGRAM_MEMORY_SIZE, 17'h00100, 14, 1'b0, '0},
        // Duplicate is reported before a full table; an absent address hits the full table.
        '{ROW_CMD, OP_SET, CFG_PROGRAM_MEMORY_SIZE, 17'h0FFFF, 1, 1'b1,
          '{1'b1, 1'b0, STAT_PRESENT, 5'd16}},
        '{ROW_CMD, OP_SET, CFG_PROGRAM_MEMORY_SIZE, 17'h00200, 1, 1'b1,
          '{1'b0, 1'b0, STAT_FULL, 5'd16}},
        '{ROW_CMD, OP_TOGGLE, CFG_PROGRAM_MEMORY_SIZE, 17'h00200, 1, 1'b1,
          '{1'b0, 1'b0, STAT_FULL, 5'd16}},
        // Clear slot 0; the last entry moves into it and must still be found.
        '{ROW_CMD, OP_CLEAR, CFG_PROGRAM_MEMORY_SIZE, 17'h00000, 1, 1'b1,
          '{1'b1, 1'b0, STAT_DONE, 5'd15}},
        '{ROW_CMD, OP_LOOKUP, CFG_PROGRAM_MEMORY_SIZE, 17'h0010D, 1, 1'b1,
          '{1'b1, 1'b0, STAT_DONE, 5'd15}},
        // Toggle twice: set path, then clear path.
        '{ROW_CMD, OP_TOGGLE, CFG_PROGRAM_MEMORY_SIZE, 17'h05555, 1, 1'b0, '0},
        '{ROW_CMD, OP_TOGGLE, CFG_PROGRAM_MEMORY_SIZE, 17'h05555, 1, 1'b0, '0},
        '{ROW_CMD, OP_CLEAR, CFG_PROGRAM_MEMORY_SIZE, 17'h01234, 1, 1'b1,
          '{1'b0, 1'b0, STAT_NOT_FOUND, 5'd15}},
        '{ROW_CMD, OP_UNUSED_LAST, CFG_PROGRAM_MEMORY_SIZE, 17'h0FFFF, 1, 1'b1,
          '{1'b1, 1'b0, STAT_DONE, 5'd15}},
        // Shrink the memory below a stored entry and arm the stop point on it.
        '{ROW_REG_WRITE, OP_LOOKUP, CFG_PROGRAM_MEMORY_SIZE, 17'h08000, 1, 1'b0, '0},
        '{ROW_REG_WRITE, OP_LOOKUP, CFG_STOP_ADDRESS, 17'h0FFFF, 1, 1'b0, '0},
        '{ROW_CMD, OP_LOOKUP, CFG_PROGRAM_MEMORY_SIZE, 17'h0FFFF, 1, 1'b1,
          '{1'b1, 1'b1, STAT_DONE, 5'd15}},
        // The stranded entry can no longer be cleared, and nothing at the size can be set.
        '{ROW_CMD, OP_CLEAR, CFG_PROGRAM_MEMORY_SIZE, 17'h0FFFF, 1, 1'b1,
          '{1'b1, 1'b1, STAT_BAD_ADDRESS, 5'd15}},
        '{ROW_CMD, OP_SET, CFG_PROGRAM_MEMORY_SIZE, 17'h08000, 1, 1'b1,
          '{1'b0, 1'b0, STAT_BAD_ADDRESS, 5'd15}},
        // Clear-all reports the hit from before it empties the table.
        '{ROW_CMD, OP_CLEAR_ALL, CFG_PROGRAM_MEMORY_SIZE, 17'h0FFFF, 1, 1'b1,
          '{1'b1, 1'b1, STAT_DONE, 5'd0}}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;   // [2:0] opcode, [18:3] address, rest zero
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;   // [0] entry_hit, [1] stop_hit,
                                     // [4:2] status, [9:5] entry_count, rest zero
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PMS_W-1:0]     cfg_wdata;

    // Predictor state: the table as the block should hold it, and its registers.
    logic [ADDR_W-1:0]    bp_entries [MAX_BREAKPOINTS];
    int                   pred_count;
    logic [PMS_W-1:0]     cur_pms;
    logic [ADDR_W-1:0]    cur_stop;

    result_t              pending_results [$];
    result_t              oldest_expected;
    int                   fail_count = 0;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   hold_off_left = 0;
    logic [ADDR_W-1:0]    addr_pool [POOL_SIZE];

    breakpoint_address_table_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    // Apply one command to the predicted table and return the result it must give.
    function automatic result_t breakpoint_cmd_result(input logic [OP_W-1:0]   op,
                                                      input logic [ADDR_W-1:0] addr);
        result_t r;
        int      slot;
        bit      hit;
        bit      addr_ok;
        bit      do_set;
        bit      do_clear;
        slot = -1;
        for (int k = 0; k < pred_count; k++)
            if (slot < 0 && bp_entries[k] == addr) slot = k;
        hit      = (slot >= 0);
        addr_ok  = ({1'b0, addr} < cur_pms);
        do_set   = (op == OP_SET) || (op == OP_TOGGLE && !hit);
        do_clear = (op == OP_CLEAR) || (op == OP_TOGGLE && hit);
        r.entry_hit = hit;
        r.stop_hit  = (cur_stop != '0) && (cur_stop == addr);
        r.status    = STAT_DONE;
        if (do_set) begin
            if (!addr_ok)
                r.status = STAT_BAD_ADDRESS;
            else if (hit)
                r.status = STAT_PRESENT;
            else if (pred_count >= MAX_BREAKPOINTS)
                r.status = STAT_FULL;
            else begin
                bp_entries[pred_count] = addr;
                pred_count++;
            end
        end
        if (do_clear) begin
            if (!addr_ok)
                r.status = STAT_BAD_ADDRESS;
            else if (!hit)
                r.status = STAT_NOT_FOUND;
            else begin
                // Move the last entry into the freed slot.
                bp_entries[slot] = bp_entries[pred_count - 1];
                pred_count--;
            end
        end
        if (op == OP_CLEAR_ALL) pred_count = 0;
        r.entry_count = OUT_CNT_W'(pred_count);
        return r;
    endfunction

    // Offer one command, after a random idle stretch, and log its expected result once
    // the transaction completes. Typed rows supply the result; the predictor still runs.
    task automatic send_cmd(input logic [OP_W-1:0]   op,
                            input logic [ADDR_W-1:0] addr,
                            input bit                use_typed,
                            input result_t           typed_res);
        int      idle_cycles;
        result_t predicted;
        idle_cycles = 0;
        while ($urandom_range(99) < send_idle_pct) idle_cycles++;
        if (idle_cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle_cycles) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, addr, op};
        do @(posedge aclk); while (!s_tready);
        predicted = breakpoint_cmd_result(op, addr);
        pending_results.push_back(use_typed ? typed_res : predicted);
    endtask

    // Drop valid and hold until every outstanding result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Write one register; call only while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PMS_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_PROGRAM_MEMORY_SIZE)
            cur_pms = value;
        else
            cur_stop = value[ADDR_W-1:0];
    endtask

    // Result sink: random back-pressure, or a long hold-off when one is requested.
    initial begin : result_sink
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_left > 0) begin
                m_tready <= 1'b0;
                hold_off_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare every result transaction with the oldest pending expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing pending: m_tdata=%h", m_tdata);
                fail_count++;
            end else begin
                oldest_expected = pending_results.pop_front();
                if (m_tdata[0] !== oldest_expected.entry_hit) begin
                    $error("entry_hit: expected %0d, actual %0d",
                           oldest_expected.entry_hit, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[1] !== oldest_expected.stop_hit) begin
                    $error("stop_hit: expected %0d, actual %0d",
                           oldest_expected.stop_hit, m_tdata[1]);
                    fail_count++;
                end
                if (m_tdata[4:2] !== oldest_expected.status) begin
                    $error("status: expected %0d, actual %0d",
                           oldest_expected.status, m_tdata[4:2]);
                    fail_count++;
                end
                if (m_tdata[9:5] !== oldest_expected.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           oldest_expected.entry_count, m_tdata[9:5]);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [PMS_W-1:0]  new_pms;
        logic [ADDR_W-1:0] new_stop;
        logic [ADDR_W-1:0] addr;
        logic [OP_W-1:0]   op;
        int                pick;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_PROGRAM_MEMORY_SIZE;
        cfg_wdata = '0;
        cur_pms   = PMS_RESET;
        cur_stop  = '0;
        pred_count = 0;
        send_idle_pct = 13;
        recv_idle_pct = 87;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed sequence: walk the table.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG_WRITE) begin
                drain_results();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end else begin
                for (int k = 0; k < directed_rows[i].reps; k++)
                    send_cmd(directed_rows[i].op, directed_rows[i].value[ADDR_W-1:0] + ADDR_W'(k),
                             directed_rows[i].typed, directed_rows[i].res);
            end
        end

        // Random phases, each under its own register setting and one of three idle patterns.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            case (ph)
                0: begin
                    new_pms  = PMS_RESET;
                    new_stop = 16'hFFFF;
                end
                1: begin
                    new_pms  = 17'd1;
                    new_stop = 16'h0001;
                end
                2: begin
                    new_pms  = 17'd0;
                    new_stop = 16'h8000;
                end
                3: begin
                    new_pms  = 17'h1FFFF;
                    new_stop = ADDR_W'($urandom);
                end
                4: begin
                    new_pms  = PMS_W'($urandom_range(40, 2));
                    new_stop = ADDR_W'($urandom_range(31, 1));
                end
                default: begin
                    new_pms  = PMS_RESET;
                    new_stop = 16'h0000;
                end
            endcase
            // Sender light and receiver heavy first, then swapped, then no idling at all.
            if (ph < 2) begin
                send_idle_pct = 13;
                recv_idle_pct = 87;
            end else if (ph < 4) begin
                send_idle_pct = 87;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(CFG_PROGRAM_MEMORY_SIZE, new_pms);
            write_reg(CFG_STOP_ADDRESS, {1'b0, new_stop});

            // A pool larger than the table keeps sets, clears and lookups colliding
            // and lets the table fill up.
            for (int p = 0; p < POOL_SIZE; p++)
                addr_pool[p] = (p % 2 == 1) ? ADDR_W'($urandom) : ADDR_W'($urandom_range(31));

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Stall the sink for a long stretch while commands keep coming, so the
                // block backs up and drops s_tready; now and then pause until drained.
                if (ph == NUM_PHASES - 1 && n == 10)
                    hold_off_left = HOLD_OFF_CYCLES;
                else if ($urandom_range(39) == 0)
                    drain_results();

                pick = $urandom_range(99);
                if (pick < 15)
                    op = OP_LOOKUP;
                else if (pick < 50)
                    op = OP_SET;
                else if (pick < 68)
                    op = OP_CLEAR;
                else if (pick < 86)
                    op = OP_TOGGLE;
                else if (pick < 89)
                    op = OP_CLEAR_ALL;
                else
                    op = OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));

                pick = $urandom_range(99);
                if (pick < 70)
                    addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
                else if (pick < 78)
                    addr = cur_stop;
                else if (pick < 86)
                    addr = cur_pms[ADDR_W-1:0];   // first address past the memory
                else if (pick < 92)
                    addr = ADDR_W'(cur_pms - 1);  // last valid address
                else
                    addr = ADDR_W'($urandom);

                send_cmd(op, addr, 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("breakpoint_address_table_top regression: pass");
        else
            $display("breakpoint_address_table_top regression: fail");
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("breakpoint_address_table_top regression: fail");
        $finish;
    end

endmodule
